@@ rtl/tea_pkg.sv @@
// ----------------------------------------------------------------------------
// TEA package
// Shared types, constants and the round mixing function of the TEA engine.
// ----------------------------------------------------------------------------
package tea_pkg;

   localparam int          TEA_ROUNDS = 32;
   localparam logic [31:0] TEA_DELTA  = 32'h9E3779B9;

   // configuration register indexes
   localparam logic [1:0] KEY0_IDX = 2'd0;
   localparam logic [1:0] KEY1_IDX = 2'd1;
   localparam logic [1:0] KEY2_IDX = 2'd2;
   localparam logic [1:0] KEY3_IDX = 2'd3;

   // request kinds
   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   typedef struct packed {
      logic [31:0] k3;
      logic [31:0] k2;
      logic [31:0] k1;
      logic [31:0] k0;
   } key_type;

   typedef struct packed {
      logic        dec;
      logic [31:0] v1;
      logic [31:0] v0;
   } blk_type;

   function automatic logic [31:0] mix_word(input logic [31:0] w, input logic [31:0] sum,
                                            input logic [31:0] ka, input logic [31:0] kb);
      mix_word = ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

endpackage

@@ rtl/tea_half_round.sv @@
// ----------------------------------------------------------------------------
// TEA half-round stage
// One registered half round: updates one of the two words with the mixing
// function of the other. Sum constants are fixed per stage for each direction.
// ----------------------------------------------------------------------------
module tea_half_round #(
   parameter int ROUNDS    = tea_pkg::TEA_ROUNDS,
   parameter int ROUND_IDX = 0,
   parameter bit HALF      = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  tea_pkg::key_type key,
   input  logic             in_valid,
   input  tea_pkg::blk_type in_blk,
   output logic             out_valid,
   output tea_pkg::blk_type out_blk
);
   import tea_pkg::*;

   localparam logic [63:0] ENC_PROD = 64'(ROUND_IDX + 1) * 64'(TEA_DELTA);
   localparam logic [63:0] DEC_PROD = 64'(ROUNDS - ROUND_IDX) * 64'(TEA_DELTA);
   localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
   localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];

   logic        valid_ff, valid_in;
   blk_type     blk_ff, blk_in;
   logic        upd_v0;
   logic [31:0] sum, src, ka, kb, mix, tgt, res;

   // encrypt: first half updates v0; decrypt: second half updates v0
   always_comb begin
      upd_v0 = (HALF == 1'b0) != (in_blk.dec == REQ_DECRYPT);
      sum    = (in_blk.dec == REQ_DECRYPT) ? DEC_SUM : ENC_SUM;
      src    = upd_v0 ? in_blk.v1 : in_blk.v0;
      tgt    = upd_v0 ? in_blk.v0 : in_blk.v1;
      ka     = upd_v0 ? key.k0 : key.k2;
      kb     = upd_v0 ? key.k1 : key.k3;
      mix    = mix_word(src, sum, ka, kb);
      res    = (in_blk.dec == REQ_DECRYPT) ? tgt - mix : tgt + mix;
      blk_in = in_blk;
      if (upd_v0) begin
         blk_in.v0 = res;
      end else begin
         blk_in.v1 = res;
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

@@ rtl/tea_out_skid.sv @@
// ----------------------------------------------------------------------------
// TEA output stage
// Output register plus one skid entry; freezes the pipeline while the skid
// entry is occupied.
// ----------------------------------------------------------------------------
module tea_out_skid (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_data,
   output logic        pipe_go,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [63:0] out_data
);
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [63:0] skid_data_ff, skid_data_in;
   logic        take;

   assign pipe_go = !skid_valid_ff;
   assign take    = pipe_go && in_valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_data_in  = in_data;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ rtl/tea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// TEA block cipher
// Fully unrolled TEA engine, encrypt or decrypt per word, one word per cycle unless the output backs up.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : input words. tdata is the 64-bit block (v0 low, v1 high), tuser
//           picks the operation (0 encrypt, 1 decrypt). Mixed streams are fine.
//   rsp_* : result words, 64-bit block, same order as the requests.
//   csr_* : key write port. csr_addr 0..3 selects k0..k3, written on csr_we.
//           Keys are read live by every stage, so change them only while
//           the engine is empty.
//   One register stage per half round, each three 32-bit adds, two xors and an
//   add/sub, plus the output register.
//   Throughput is one word per cycle while the skid entry is empty.
//   Reset (synchronous) clears all valid bits and the keys to zero.
//   A stalled receiver fills the output register, then one skid entry; with
//   the skid entry full the whole pipeline holds and req_tready drops. It
//   rises again the cycle after the skid entry drains. req_tready comes
//   straight from a flop, no path from rsp_tready.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
   parameter int ROUNDS = tea_pkg::TEA_ROUNDS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] data_block
   input  logic [0:0]  req_tuser,   // [0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] result_block
   // key writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import tea_pkg::*;

   localparam int STAGES = 2 * ROUNDS;

   key_type key_ff, key_in;
   logic    pipe_go;

   // stage i takes valid/blk[i] and drives valid/blk[i+1]
   logic    valid [STAGES+1];
   blk_type blk   [STAGES+1];

   // key registers
   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         unique case (csr_addr)
            KEY0_IDX: key_in.k0 = csr_wdata;
            KEY1_IDX: key_in.k1 = csr_wdata;
            KEY2_IDX: key_in.k2 = csr_wdata;
            KEY3_IDX: key_in.k3 = csr_wdata;
            default:  key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // pipeline entry
   assign req_tready = pipe_go;
   assign valid[0]   = req_tvalid;
   assign blk[0].dec = req_tuser[0];
   assign blk[0].v0  = req_tdata[31:0];
   assign blk[0].v1  = req_tdata[63:32];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      tea_half_round #(
         .ROUNDS    (ROUNDS),
         .ROUND_IDX (s / 2),
         .HALF      (1'(s % 2))
      ) u_half (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_go),
         .key       (key_ff),
         .in_valid  (valid[s]),
         .in_blk    (blk[s]),
         .out_valid (valid[s+1]),
         .out_blk   (blk[s+1])
      );
   end

   // output register and skid entry
   tea_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[STAGES]),
      .in_data   ({blk[STAGES].v1, blk[STAGES].v0}),
      .pipe_go   (pipe_go),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

@@ sim/tea_block_cipher_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block cipher result check
// Tracks the key writes and predicts the result of every accepted request word.
// Compares each result word, in order, with its prediction and counts
// the failures.
// ----------------------------------------------------------------------------
module tea_block_cipher_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] data_block
   input  logic [0:0]  req_tuser,    // [0] req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,    // [63:0] result_block
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import tea_pkg::*;

   key_type     key_copy;
   logic [63:0] expected_blocks[$];

   function automatic logic [31:0] feistel_term(input logic [31:0] w, input logic [31:0] sum,
                                                input logic [31:0] ka, input logic [31:0] kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

   // full 32-round TEA on one block, v0 in the low word
   function automatic logic [63:0] tea_cipher_block(input logic [63:0] blk, input logic op,
                                                    input key_type key);
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] sum;
      v0 = blk[31:0];
      v1 = blk[63:32];
      if (op == REQ_DECRYPT) begin
         sum = TEA_DELTA * 32'(TEA_ROUNDS);
         for (int r = 0; r < TEA_ROUNDS; r++) begin
            v1  = v1 - feistel_term(v0, sum, key.k2, key.k3);
            v0  = v0 - feistel_term(v1, sum, key.k0, key.k1);
            sum = sum - TEA_DELTA;
         end
      end else begin
         sum = '0;
         for (int r = 0; r < TEA_ROUNDS; r++) begin
            sum = sum + TEA_DELTA;
            v0  = v0 + feistel_term(v1, sum, key.k0, key.k1);
            v1  = v1 + feistel_term(v0, sum, key.k2, key.k3);
         end
      end
      return {v1, v0};
   endfunction

   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         key_copy   <= '0;
         fail_count <= 0;
         pending    <= 0;
         expected_blocks.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               KEY0_IDX: key_copy.k0 <= csr_wdata;
               KEY1_IDX: key_copy.k1 <= csr_wdata;
               KEY2_IDX: key_copy.k2 <= csr_wdata;
               KEY3_IDX: key_copy.k3 <= csr_wdata;
               default: ;
            endcase
         end
         // pop before push so a result never matches a word accepted at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               $error("result word %h arrived with nothing expected", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata !== want) begin
                  $error("result_block mismatch: expected %h, actual %h", want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_blocks.push_back(tea_cipher_block(req_tdata, req_tuser[0], key_copy));
         pending <= expected_blocks.size();
      end
   end

endmodule

@@ sim/tea_block_cipher_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// Drives encrypt and decrypt words through the engine under several keys,
// with random idle cycles on both sides and one long output stall. A separate
// check module predicts every result; this module makes stimulus and reports.
// ----------------------------------------------------------------------------
module tea_block_cipher_tb;
   import tea_pkg::*;

   localparam int LATENCY       = 2 * TEA_ROUNDS + 1;  // engine depth: half-round stages plus the output register
   localparam int HOLD_CYCLES   = 300;                 // long receiver hold-off
   localparam int WORDS_PER_KEY = 170;                 // random words per key setting
   localparam int RANDOM_KEYS   = 5;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [63:0] data_block
   logic [0:0]  req_tuser  = '0;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [63:0] result_block
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [31:0] csr_wdata  = '0;

   int   fail_count;
   int   pending;

   // shared between the sender and receiver processes, plus the run counters
   logic steady    = 1'b0;   // no idling on either side while set
   logic hold_rsp  = 1'b0;   // asks the receiver for one long hold-off
   int   words_sent   = 0;
   int   decrypt_sent = 0;
   int   key_settings = 1;   // reset key counts as the first
   int   holds_done   = 0;

   always #2 clock = ~clock;

   tea_block_cipher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tea_block_cipher_check check_u (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offer one word, with random idle cycles ahead of it unless in the steady
   // stretch. Returns right after the edge that accepted it, with tvalid still
   // high, so back-to-back words never drop tvalid within one step.
   task automatic send_word(input logic op, input logic [63:0] blk);
      while (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (op == REQ_DECRYPT) decrypt_sent++;
   endtask

   // Wait until every result is back and the pipeline has settled.
   task automatic drain_engine();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Key writes, one register per cycle; only called with the engine empty.
   task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
      logic [31:0] words[4];
      words = '{k0, k1, k2, k3};
      foreach (words[i]) begin
         csr_we    <= 1'b1;
         csr_addr  <= 2'(i);
         csr_wdata <= words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      key_settings++;
   endtask

   // Mostly dense random blocks, some single-bit and single-hole patterns.
   function automatic logic [63:0] random_block();
      case ($urandom_range(7))
         0:       return 64'h1 << $urandom_range(63);
         1:       return ~(64'h1 << $urandom_range(63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Receiver: random stalls, none in the steady stretch, and one long
   // hold-off on request so the engine backs up and drops req_tready.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 18);
         end
      end
   end

   // Stimulus
   initial begin
      logic [63:0] edge_blocks[8];
      edge_blocks = '{64'h0, '1, 64'h00000000_FFFFFFFF, 64'hFFFFFFFF_00000000,
                      64'h80000000_00000001, 64'h55555555_55555555,
                      64'hAAAAAAAA_AAAAAAAA, 64'h01234567_89ABCDEF};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edge blocks both ways under the all-zero reset key
      foreach (edge_blocks[i]) begin
         send_word(REQ_ENCRYPT, edge_blocks[i]);
         send_word(REQ_DECRYPT, edge_blocks[i]);
      end
      drain_engine();

      // directed: all-ones key, where every key add carries all the way
      load_keys('1, '1, '1, '1);
      send_word(REQ_ENCRYPT, 64'h0);
      send_word(REQ_DECRYPT, 64'h0);
      send_word(REQ_ENCRYPT, '1);
      send_word(REQ_DECRYPT, '1);
      drain_engine();

      // random words under several keys; alternating pattern key in the middle
      for (int ks = 0; ks < RANDOM_KEYS; ks++) begin
         if (ks == 2)
            load_keys(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA);
         else
            load_keys($urandom, $urandom, $urandom, $urandom);
         for (int n = 0; n < WORDS_PER_KEY; n++) begin
            // full-rate stretch with no idling on either side
            if (ks == 1) steady = (n >= 20 && n < 140);
            // long receiver hold-off while the sender keeps offering
            if (ks == 3 && n == 20) hold_rsp = 1'b1;
            send_word(1'($urandom_range(1)), random_block());
         end
         steady = 1'b0;
         drain_engine();
      end

      // final settle, then verdict
      repeat (LATENCY + 5) @(posedge clock);
      $display("Sent %0d words (%0d decrypt) under %0d key settings, zero and all-ones keys",
               words_sent, decrypt_sent, key_settings);
      $display("included; %0d long output hold-off(s) with the input backed up.", holds_done);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS tea_block_cipher");
      end else begin
         $display("FAIL tea_block_cipher");
      end
      $finish;
   end

   // hard limit, far beyond the slowest correct run
   initial begin
      #200000;
      $display("FAIL tea_block_cipher");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tea_pkg.sv
rtl/tea_half_round.sv
rtl/tea_out_skid.sv
rtl/tea_block_cipher.sv
sim/tea_block_cipher_check.sv
sim/tea_block_cipher_tb.sv
